[hdl/bdlp_pkg.sv]
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the button debounce / long-press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int FIELD_COUNT = 5;
	localparam int CFG_W       = 16;
	localparam int IDX_W       = 2;
	localparam int STAMP_W     = 32;
	localparam int LEVELS_W    = 5;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} ev_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_time;
		logic [CFG_W-1:0] long_press_time;
	} cfg_t;

endpackage

[hdl/bdlp_if.sv]
// ----------------------------------------------------------------------------
// bdlp_if
// Valid/ready channels: raw button samples in, per-button events out.
// ----------------------------------------------------------------------------
interface bdlp_sample_if;
	logic        valid;
	logic        ready;
	logic [4:0]  button_levels;
	logic [31:0] now_ms;

	modport source (output valid, output button_levels, output now_ms, input ready);
	modport sink   (input valid, input button_levels, input now_ms, output ready);
endinterface

interface bdlp_event_if;
	logic       valid;
	logic       ready;
	logic [1:0] up_event;
	logic [1:0] down_event;
	logic [1:0] left_event;
	logic [1:0] right_event;
	logic [1:0] center_event;

	modport source (output valid, output up_event, output down_event, output left_event,
		output right_event, output center_event, input ready);
	modport sink   (input valid, input up_event, input down_event, input left_event,
		input right_event, input center_event, output ready);
endinterface

[hdl/bdlp_button.sv]
// ----------------------------------------------------------------------------
// bdlp_button
// One button: debounced level, last change time, long-press flag.
// ----------------------------------------------------------------------------
module bdlp_button
	import bdlp_pkg::*;
#(
	parameter int TIME_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  raw,
	input  logic [TIME_WIDTH-1:0] now,
	input  cfg_t                  cfg,
	output ev_t                   ev
);

	logic                  stable_level_q;
	logic                  long_flag_q;
	logic [TIME_WIDTH-1:0] change_time_q;

	logic [TIME_WIDTH-1:0] elapsed;
	logic                  take_change;
	logic                  short_hit;
	logic                  long_hit;

	assign elapsed     = now - change_time_q;
	assign take_change = (raw != stable_level_q) &&
		(elapsed > {{(TIME_WIDTH-CFG_W){1'b0}}, cfg.debounce_time});
	assign short_hit   = take_change && raw && !long_flag_q;
	// an accepted change zeroes the hold time, so no long press that step
	assign long_hit    = !raw && !long_flag_q && !take_change &&
		(elapsed > {{(TIME_WIDTH-CFG_W){1'b0}}, cfg.long_press_time});

	always_comb begin
		if (long_hit) begin
			ev = EV_LONG;
		end else if (short_hit) begin
			ev = EV_SHORT;
		end else begin
			ev = EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q <= 1'b1;
			long_flag_q    <= 1'b0;
			change_time_q  <= '0;
		end else if (en) begin
			if (take_change) begin
				stable_level_q <= raw;
				change_time_q  <= now;
			end
			if (long_hit) begin
				long_flag_q <= 1'b1;
			end else if (take_change && raw) begin
				long_flag_q <= 1'b0;
			end
		end
	end

	a_long_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev == EV_LONG |=> long_flag_q)
		else $error("long press without flag");

	a_short_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev == EV_SHORT |=> stable_level_q && !long_flag_q && !$past(stable_level_q))
		else $error("short press without release");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stable_level_q) && $stable(long_flag_q) && $stable(change_time_q))
		else $error("state moved without a beat");

endmodule

[hdl/button_debounce_long_press_core.sv]
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Debounce and short/long press classification for up to five buttons.
// Path: input reg, then result reg; per-button event logic is combinational.
// Throughput: one sample per cycle while the result channel is not stalled.
// Reset: levels released, change times and long flags zero, debounce 50 ms,
// long press 1000 ms; pipeline empty.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core
	import bdlp_pkg::*;
#(
	parameter int NUM_BUTTONS = 5,
	parameter int TIME_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	bdlp_sample_if.sink       sample,
	bdlp_event_if.source      result,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic [LEVELS_W-1:0]   levels_s1;
	logic [STAMP_W-1:0]    stamp_s1;
	logic [TIME_WIDTH-1:0] now;
	logic                  out_valid_q;
	ev_t                   ev_q   [FIELD_COUNT];
	ev_t                   ev_all [FIELD_COUNT];
	logic                  advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RST;
			cfg_q.long_press_time <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_time   <= cfg_wdata;
				REG_LONG_PRESS: cfg_q.long_press_time <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			levels_s1 <= sample.button_levels;
			stamp_s1  <= sample.now_ms;
		end
	end

	generate
		if (TIME_WIDTH <= STAMP_W) begin : g_now_narrow
			assign now = stamp_s1[TIME_WIDTH-1:0];
		end else begin : g_now_wide
			assign now = {{(TIME_WIDTH-STAMP_W){1'b0}}, stamp_s1};
		end
	endgenerate

	genvar gi;
	generate
		for (gi = 0; gi < FIELD_COUNT; gi++) begin : g_btn
			if (gi < NUM_BUTTONS) begin : g_live
				bdlp_button #(.TIME_WIDTH(TIME_WIDTH)) u_button (
					.clk    (clk),
					.arst_n (arst_n),
					.en     (advance),
					.raw    (levels_s1[gi]),
					.now    (now),
					.cfg    (cfg_q),
					.ev     (ev_all[gi])
				);
			end else begin : g_absent
				assign ev_all[gi] = EV_NONE;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_q <= ev_all;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.up_event     = ev_q[0];
	assign result.down_event   = ev_q[1];
	assign result.left_event   = ev_q[2];
	assign result.right_event  = ev_q[3];
	assign result.center_event = ev_q[4];

endmodule
